@@ hdl/grtr_pkg.sv @@
// Package for the glyph row tile rasterizer: 5x7 glyph ROM, character codes,
// register indexes and the configuration struct.
// No dependencies.
package grtr_pkg;

	// Number of glyph rows and columns
	localparam int unsigned GLYPH_ROWS = 7;
	localparam int unsigned GLYPH_COLS = 5;
	localparam int unsigned GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

	// Register indexes on the configuration port
	localparam logic REG_INK     = 1'b0;
	localparam logic REG_OUTLINE = 1'b1;

	// Mode codes
	localparam logic MODE_PLAIN    = 1'b0;
	localparam logic MODE_OUTLINED = 1'b1;

	// Last glyph row; the row after it is blank
	localparam logic [2:0] ROW_LAST  = 3'd6;
	localparam logic [2:0] ROW_FIRST = 3'd0;

	// Character codes
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_PERIOD  = 8'h2E;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_EXCLAIM = 8'h21;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_STAR    = 8'h2A;

	// Color registers handed to the row renderer
	typedef struct packed {
		logic [3:0] ink;
		logic [3:0] outline;
	} cfg_t;

	typedef logic [GLYPH_BITS-1:0] glyph_t;

	// Glyphs: row 0 in the top five bits, MSB of each row is the leftmost column
	localparam glyph_t DIGIT_GLYPHS [10] = '{
		{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
		{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
		{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
		{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
		{5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
		{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
		{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
		{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12}
	};

	localparam glyph_t LETTER_GLYPHS [26] = '{
		{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
		{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
		{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
		{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
		{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		{5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12},
		{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
		{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
		{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
		{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
		{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
		{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
		{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
		{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
		{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
		{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
		{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
		{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
		{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
	};

	// Punctuation glyphs; unlisted codes are blank
	function automatic glyph_t symbol_glyph(input logic [7:0] code);
		glyph_t g;
		case (code)
			CH_MINUS:   g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
			CH_UNDER:   g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31};
			CH_BAR:     g = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
			CH_PLUS:    g = {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};
			CH_GREATER: g = {5'd16, 5'd8,  5'd4,  5'd2,  5'd4,  5'd8,  5'd16};
			CH_LESS:    g = {5'd1,  5'd2,  5'd4,  5'd8,  5'd4,  5'd2,  5'd1};
			CH_SLASH:   g = {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16};
			CH_QUEST:   g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd0,  5'd4};
			CH_LBRACK:  g = {5'd14, 5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd14};
			CH_RBRACK:  g = {5'd14, 5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd14};
			CH_COLON:   g = {5'd0,  5'd0,  5'd4,  5'd0,  5'd0,  5'd4,  5'd0};
			CH_PERIOD:  g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4};
			CH_COMMA:   g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4,  5'd8};
			CH_EXCLAIM: g = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4};
			CH_EQUAL:   g = {5'd0,  5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0};
			CH_STAR:    g = {5'd0,  5'd0,  5'd21, 5'd14, 5'd0,  5'd0,  5'd0};
			default:    g = '0;
		endcase
		return g;
	endfunction

	// Whole glyph for a code; lower case folds to upper case
	function automatic glyph_t glyph_of(input logic [7:0] code);
		logic [7:0] off;
		glyph_t     g;
		off = '0;
		if (code >= CH_0 && code <= CH_9) begin
			off = code - CH_0;
			g = DIGIT_GLYPHS[off[3:0]];
		end else if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
			off = code - CH_UPPER_A;
			g = LETTER_GLYPHS[off[4:0]];
		end else if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
			off = code - CH_LOWER_A;
			g = LETTER_GLYPHS[off[4:0]];
		end else begin
			g = symbol_glyph(code);
		end
		return g;
	endfunction

	// One 5-bit glyph row; the row past the last is blank
	function automatic logic [GLYPH_COLS-1:0] row_bits_of(input glyph_t g,
		input logic [2:0] row);
		logic [GLYPH_COLS-1:0] bits;
		case (row)
			3'd0:    bits = g[34:30];
			3'd1:    bits = g[29:25];
			3'd2:    bits = g[24:20];
			3'd3:    bits = g[19:15];
			3'd4:    bits = g[14:10];
			3'd5:    bits = g[9:5];
			3'd6:    bits = g[4:0];
			default: bits = '0;
		endcase
		return bits;
	endfunction

endpackage

@@ hdl/grtr_row_render.sv @@
// Row renderer: glyph lookup for the current row and its neighbors, then
// plain or outlined expansion into eight 4-bit pixels.
// Depends on grtr_pkg.
module grtr_row_render
	import grtr_pkg::*;
(
	input  logic [7:0]  char_code,
	input  logic [2:0]  tile_row,
	input  logic        mode,
	input  cfg_t        cfg,
	output logic [31:0] row_pixels
);

	glyph_t                glyph;
	logic [GLYPH_COLS-1:0] cur_bits;
	logic [GLYPH_COLS-1:0] up_bits;
	logic [GLYPH_COLS-1:0] dn_bits;
	logic [6:0]            line;
	logic [6:0]            halo;
	logic [2:0]            row_up;
	logic [2:0]            row_dn;

	// Look up this row and the rows above and below
	assign glyph    = glyph_of(char_code);
	assign row_up   = tile_row - 3'd1;
	assign row_dn   = tile_row + 3'd1;
	assign cur_bits = row_bits_of(glyph, tile_row);
	assign up_bits  = (tile_row != ROW_FIRST) ? row_bits_of(glyph, row_up) : '0;
	assign dn_bits  = (tile_row < ROW_LAST) ? row_bits_of(glyph, row_dn) : '0;

	// Widen to seven columns and grow the outline
	assign line = {1'b0, cur_bits, 1'b0};
	assign halo = line | {line[5:0], 1'b0} | {1'b0, line[6:1]}
		| {1'b0, up_bits, 1'b0} | {1'b0, dn_bits, 1'b0};

	// Expand into pixels, leftmost in the lowest nibble
	always_comb begin
		row_pixels = '0;
		if (mode == MODE_PLAIN) begin
			for (int col = 0; col < 5; col++) begin
				if (cur_bits[4-col]) begin
					row_pixels[(col+1)*4 +: 4] = 4'd1;
				end
			end
		end else begin
			for (int col = 0; col < 7; col++) begin
				if (line[6-col]) begin
					row_pixels[col*4 +: 4] = cfg.ink;
				end else if (halo[6-col]) begin
					row_pixels[col*4 +: 4] = cfg.outline;
				end
			end
		end
	end

endmodule

@@ hdl/glyph_row_tile_rasterizer.sv @@
// Top level of the glyph row tile rasterizer: input register, row renderer,
// result register and the color registers. Depends on grtr_pkg, grtr_row_render.
//
// Usage:
//   s_axis carries one request item: tdata holds char_code and tile_row,
//   tuser holds the mode bit (0 plain, 1 outlined). m_axis returns one
//   32-bit tile row per request, eight 4-bit pixels, pixel 0 in the low nibble.
//   The cfg channel writes ink_color (index 0) and outline_color (index 1);
//   cfg_ready is always high and writes belong to idle periods.
// Timing:
//   One item per cycle sustained while m_axis_tready stays high. The request
//   is registered in the input register; the glyph ROM lookup and pixel
//   expansion run between that register and the result register, which
//   drives m_axis.
// Reset:
//   arst_n clears both pipeline valids and sets both colors to 1.
// Stall:
//   When m_axis_tready is low the result holds; the input register still
//   fills, so one more item is taken before s_axis_tready drops.
module glyph_row_tile_rasterizer
	import grtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] char_code, [10:8] tile_row, rest zero
	input  logic        s_axis_tuser,  // [0] mode
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] row_pixels
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	logic        valid_s1;
	logic [7:0]  code_s1;
	logic [2:0]  row_s1;
	logic        mode_s1;
	logic        valid_s2;
	logic [31:0] pixels_s2;
	logic [31:0] pixels;
	logic        s2_ready;
	cfg_t        cfg_q;

	// Pipeline handshake
	assign s2_ready      = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s2_ready;
	assign cfg_ready     = 1'b1;

	// Color registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ink     <= 4'd1;
			cfg_q.outline <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INK:     cfg_q.ink <= cfg_data;
				REG_OUTLINE: cfg_q.outline <= cfg_data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			code_s1 <= s_axis_tdata[7:0];
			row_s1  <= s_axis_tdata[10:8];
			mode_s1 <= s_axis_tuser;
		end
	end

	grtr_row_render u_render (
		.char_code  (code_s1),
		.tile_row   (row_s1),
		.mode       (mode_s1),
		.cfg        (cfg_q),
		.row_pixels (pixels)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			pixels_s2 <= pixels;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = pixels_s2;

	// An item in the input register moves to the output when it has room
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s2_ready |=> m_axis_tvalid)
		else $error("item in input register did not reach the output");

	// Input stalls only when both registers are full and the output is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a full pipeline");

	// Pixel seven is never drawn
	a_pixel7: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
		else $error("pixel seven is not blank");

endmodule

@@ verif/glyph_row_tile_rasterizer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for glyph_row_tile_rasterizer: directed and random tile-row
// requests across color settings and idle patterns, checked against an in-bench font.
// Depends on grtr_pkg and the glyph_row_tile_rasterizer RTL.
module glyph_row_tile_rasterizer_tb;
	import grtr_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 11;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 188;
	localparam int DRAIN_CYCLES    = 4;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int NUM_DIRECTED    = 25;
	localparam int REPORT_LIMIT    = 10;

	// Codes with no glyph
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_BRACE = 8'h7B;
	localparam logic [7:0] CH_EXT   = 8'h80;
	localparam logic [7:0] CH_HIGH  = 8'hFF;

	typedef struct packed {
		logic [7:0]  code;
		logic [2:0]  row;
		logic        mode;
		logic        typed;
		logic [31:0] pixels;
	} stim_row_t;

	typedef struct {
		logic [7:0]  code;
		logic [2:0]  row;
		logic        mode;
		logic [31:0] pixels;
	} row_expect_t;

	// Directed requests; pixels are given only where obvious at a glance
	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{CH_NUL,     3'd0, MODE_PLAIN,    1'b1, 32'h0000_0000},
		'{CH_HIGH,    3'd7, MODE_OUTLINED, 1'b1, 32'h0000_0000},
		'{CH_EXT,     3'd3, MODE_OUTLINED, 1'b1, 32'h0000_0000},
		'{CH_AT,      3'd4, MODE_OUTLINED, 1'b1, 32'h0000_0000},
		'{CH_BRACE,   3'd2, MODE_PLAIN,    1'b1, 32'h0000_0000},
		'{CH_MINUS,   3'd3, MODE_PLAIN,    1'b1, 32'h0011_1110},
		'{CH_MINUS,   3'd3, MODE_OUTLINED, 1'b1, 32'h0111_1111},
		'{CH_UNDER,   3'd7, MODE_PLAIN,    1'b1, 32'h0000_0000},
		'{CH_BAR,     3'd0, MODE_PLAIN,    1'b1, 32'h0000_1000},
		'{CH_UNDER,   3'd7, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_PERIOD,  3'd6, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_0,       3'd0, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_9,       3'd6, MODE_PLAIN,    1'b0, 32'h0},
		'{CH_UPPER_A, 3'd3, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_UPPER_Z, 3'd6, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_LOWER_A, 3'd3, MODE_PLAIN,    1'b0, 32'h0},
		'{CH_LOWER_Z, 3'd0, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_PLUS,    3'd0, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_GREATER, 3'd4, MODE_PLAIN,    1'b0, 32'h0},
		'{CH_LESS,    3'd1, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_SLASH,   3'd5, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_QUEST,   3'd5, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_EXCLAIM, 3'd5, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_STAR,    3'd2, MODE_OUTLINED, 1'b0, 32'h0},
		'{CH_EQUAL,   3'd3, MODE_OUTLINED, 1'b0, 32'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;    // [7:0] char_code, [10:8] tile_row, rest zero
	logic        s_axis_tuser = 1'b0;  // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [31:0] row_pixels
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_INK;
	logic [3:0]  cfg_data = '0;

	// Color registers as the block should hold them
	logic [3:0] ink_now = 4'd1;
	logic [3:0] outline_now = 4'd1;

	row_expect_t expected_rows [$];
	int rows_sent = 0;
	int rows_checked = 0;
	int mismatches = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int idle_cycles = 0;

	glyph_row_tile_rasterizer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Pack seven 5-bit glyph rows, top row in the high bits
	function automatic logic [34:0] pack7(input int a, input int b, input int c,
		input int d, input int e, input int f, input int g);
		logic [4:0] ra, rb, rc, rd, re, rf, rg;
		ra = 5'(a); rb = 5'(b); rc = 5'(c); rd = 5'(d);
		re = 5'(e); rf = 5'(f); rg = 5'(g);
		return {ra, rb, rc, rd, re, rf, rg};
	endfunction

	function automatic logic [34:0] font_digit(input int d);
		case (d)
			0: return pack7(14, 17, 19, 21, 25, 17, 14);
			1: return pack7(4, 12, 4, 4, 4, 4, 14);
			2: return pack7(14, 17, 1, 2, 4, 8, 31);
			3: return pack7(30, 1, 1, 14, 1, 1, 30);
			4: return pack7(2, 6, 10, 18, 31, 2, 2);
			5: return pack7(31, 16, 16, 30, 1, 1, 30);
			6: return pack7(6, 8, 16, 30, 17, 17, 14);
			7: return pack7(31, 1, 2, 4, 8, 8, 8);
			8: return pack7(14, 17, 17, 14, 17, 17, 14);
			default: return pack7(14, 17, 17, 15, 1, 2, 12);
		endcase
	endfunction

	function automatic logic [34:0] font_letter(input int l);
		case (l)
			0:  return pack7(14, 17, 17, 31, 17, 17, 17);
			1:  return pack7(30, 17, 17, 30, 17, 17, 30);
			2:  return pack7(14, 17, 16, 16, 16, 17, 14);
			3:  return pack7(30, 17, 17, 17, 17, 17, 30);
			4:  return pack7(31, 16, 16, 30, 16, 16, 31);
			5:  return pack7(31, 16, 16, 30, 16, 16, 16);
			6:  return pack7(14, 17, 16, 23, 17, 17, 15);
			7:  return pack7(17, 17, 17, 31, 17, 17, 17);
			8:  return pack7(14, 4, 4, 4, 4, 4, 14);
			9:  return pack7(7, 2, 2, 2, 2, 18, 12);
			10: return pack7(17, 18, 20, 24, 20, 18, 17);
			11: return pack7(16, 16, 16, 16, 16, 16, 31);
			12: return pack7(17, 27, 21, 21, 17, 17, 17);
			13: return pack7(17, 25, 21, 19, 17, 17, 17);
			14: return pack7(14, 17, 17, 17, 17, 17, 14);
			15: return pack7(30, 17, 17, 30, 16, 16, 16);
			16: return pack7(14, 17, 17, 17, 21, 18, 13);
			17: return pack7(30, 17, 17, 30, 20, 18, 17);
			18: return pack7(15, 16, 16, 14, 1, 1, 30);
			19: return pack7(31, 4, 4, 4, 4, 4, 4);
			20: return pack7(17, 17, 17, 17, 17, 17, 14);
			21: return pack7(17, 17, 17, 17, 17, 10, 4);
			22: return pack7(17, 17, 17, 21, 21, 21, 10);
			23: return pack7(17, 17, 10, 4, 10, 17, 17);
			24: return pack7(17, 17, 10, 4, 4, 4, 4);
			default: return pack7(31, 1, 2, 4, 8, 16, 31);
		endcase
	endfunction

	// Punctuation row; row must be 0..6
	function automatic logic [4:0] symbol_row(input logic [7:0] c, input int r);
		logic [34:0] g;
		g = '0;
		case (c)
			CH_MINUS:   return (r == 3) ? 5'd31 : 5'd0;
			CH_UNDER:   return (r == 6) ? 5'd31 : 5'd0;
			CH_BAR:     return 5'd4;
			CH_COLON:   return (r == 2 || r == 5) ? 5'd4 : 5'd0;
			CH_PERIOD:  return (r == 6) ? 5'd4 : 5'd0;
			CH_COMMA:   return (r == 5) ? 5'd4 : ((r == 6) ? 5'd8 : 5'd0);
			CH_EXCLAIM: return (r < 5 || r == 6) ? 5'd4 : 5'd0;
			CH_EQUAL:   return (r == 2 || r == 4) ? 5'd31 : 5'd0;
			CH_STAR:    return (r == 2) ? 5'd21 : ((r == 3) ? 5'd14 : 5'd0);
			CH_PLUS:    g = pack7(0, 4, 4, 31, 4, 4, 0);
			CH_GREATER: g = pack7(16, 8, 4, 2, 4, 8, 16);
			CH_LESS:    g = pack7(1, 2, 4, 8, 4, 2, 1);
			CH_SLASH:   g = pack7(1, 1, 2, 4, 8, 16, 16);
			CH_QUEST:   g = pack7(14, 17, 1, 2, 4, 0, 4);
			CH_LBRACK:  g = pack7(14, 8, 8, 8, 8, 8, 14);
			CH_RBRACK:  g = pack7(14, 2, 2, 2, 2, 2, 14);
			default:    return 5'd0;
		endcase
		return g[34 - 5 * r -: 5];
	endfunction

	// Glyph row for any code; row seven and unknown codes are blank
	function automatic logic [4:0] font_row(input logic [7:0] code, input int r);
		logic [7:0] c;
		c = code;
		if (r >= 7)
			return 5'd0;
		if (c >= CH_0 && c <= CH_9)
			return 5'(font_digit(int'(c - CH_0)) >> (5 * (6 - r)));
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			c = c - (CH_LOWER_A - CH_UPPER_A);
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			return 5'(font_letter(int'(c - CH_UPPER_A)) >> (5 * (6 - r)));
		return symbol_row(c, r);
	endfunction

	// Expected tile row for one request at the given colors
	function automatic logic [31:0] predict_row_pixels(input logic [7:0] code,
		input logic [2:0] row, input logic mode, input logic [3:0] ink,
		input logic [3:0] outline);
		logic [7:0]  line;
		logic [7:0]  halo;
		logic [31:0] px;
		int          r;
		r = int'(row);
		px = '0;
		line = {2'b0, font_row(code, r), 1'b0};
		if (mode == MODE_PLAIN) begin
			for (int col = 0; col < 5; col++)
				if (line[5 - col])
					px[(col + 1) * 4 +: 4] = 4'd1;
		end else begin
			halo = line | (line << 1) | (line >> 1);
			if (r > 0)
				halo = halo | {2'b0, font_row(code, r - 1), 1'b0};
			if (r < 6)
				halo = halo | {2'b0, font_row(code, r + 1), 1'b0};
			for (int col = 0; col < 7; col++) begin
				if (line[6 - col])
					px[col * 4 +: 4] = ink;
				else if (halo[6 - col])
					px[col * 4 +: 4] = outline;
			end
		end
		return px;
	endfunction

	function automatic logic [7:0] symbol_code(input int i);
		case (i)
			0:  return CH_MINUS;
			1:  return CH_UNDER;
			2:  return CH_BAR;
			3:  return CH_PLUS;
			4:  return CH_GREATER;
			5:  return CH_LESS;
			6:  return CH_SLASH;
			7:  return CH_QUEST;
			8:  return CH_LBRACK;
			9:  return CH_RBRACK;
			10: return CH_COLON;
			11: return CH_PERIOD;
			12: return CH_COMMA;
			13: return CH_EXCLAIM;
			14: return CH_EQUAL;
			default: return CH_STAR;
		endcase
	endfunction

	// Mostly codes with a glyph, the rest anywhere in 0..255
	function automatic logic [7:0] pick_code();
		int sel;
		sel = $urandom_range(99);
		if (sel < 20)
			return CH_0 + 8'($urandom_range(9));
		if (sel < 35)
			return CH_UPPER_A + 8'($urandom_range(25));
		if (sel < 50)
			return CH_LOWER_A + 8'($urandom_range(25));
		if (sel < 72)
			return symbol_code($urandom_range(15));
		return 8'($urandom_range(255));
	endfunction

	// Offer one request, wait for its acceptance, and queue its expected row
	task automatic send_row(input logic [7:0] code, input logic [2:0] row,
		input logic mode, input logic typed, input logic [31:0] typed_pixels);
		row_expect_t e;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, row, code};
		s_axis_tuser <= mode;
		do @(posedge clk); while (!s_axis_tready);
		e.code = code;
		e.row = row;
		e.mode = mode;
		e.pixels = typed ? typed_pixels
			: predict_row_pixels(code, row, mode, ink_now, outline_now);
		expected_rows.push_back(e);
		rows_sent++;
		@(negedge clk);
	endtask

	// Write one color register; the caller lowers cfg_valid
	task automatic write_reg(input logic idx, input logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_INK)
			ink_now = val;
		else
			outline_now = val;
		@(negedge clk);
	endtask

	// Wait for every queued row to come back, then let the pipeline settle
	task automatic drain();
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Drive the result ready: a counted hold when asked, random stalls otherwise
	initial begin : result_ready_drive
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare each returned row with the oldest expectation
	always @(posedge clk) begin : result_check
		row_expect_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rows.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: unexpected row %08h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_rows.pop_front();
				rows_checked++;
				if (m_axis_tdata !== want.pixels) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: code %02h row %0d mode %0d expected %08h got %08h",
							$time, want.code, want.row, want.mode, want.pixels,
							m_axis_tdata);
					mismatches++;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d rows outstanding",
				idle_cycles, expected_rows.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] code;
		logic       mode;
		int         phase_items;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Set colors while idle; the first phase keeps the reset values
			if (p > 0) begin
				drain();
				case (p)
					1: begin write_reg(REG_INK, 4'd0);  write_reg(REG_OUTLINE, 4'd15); end
					2: begin write_reg(REG_INK, 4'd15); write_reg(REG_OUTLINE, 4'd0);  end
					3: begin write_reg(REG_INK, 4'd15); write_reg(REG_OUTLINE, 4'd15); end
					4: begin write_reg(REG_INK, 4'd0);  write_reg(REG_OUTLINE, 4'd0);  end
					default: begin
						write_reg(REG_INK, 4'($urandom_range(15)));
						write_reg(REG_OUTLINE, 4'($urandom_range(15)));
					end
				endcase
				cfg_valid <= 1'b0;
				@(negedge clk);
			end

			// Pick the idle pattern for this phase
			case (p)
				1:       begin sender_idle_pct = 57; recv_stall_pct = 0;  end
				2:       begin sender_idle_pct = 0;  recv_stall_pct = 57; end
				3, 5:    begin sender_idle_pct = 18; recv_stall_pct = 18; end
				default: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
			endcase

			// Directed rows under a long output hold so the input backs up
			if (p == 0) begin
				hold_request = 1;
				foreach (DIRECTED_ROWS[i])
					send_row(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].row,
						DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].typed,
						DIRECTED_ROWS[i].pixels);
			end

			// Random part: whole glyph scans mixed with single rows
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				code = pick_code();
				mode = 1'($urandom_range(1));
				if ($urandom_range(1)) begin
					for (int r = 0; r < 8; r++)
						send_row(code, 3'(r), mode, 1'b0, 32'h0);
					phase_items += 8;
				end else begin
					send_row(code, 3'($urandom_range(7)), mode, 1'b0, 32'h0);
					phase_items++;
				end
			end
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end

		drain();
		$display("Run covered %0d tile rows (%0d checked) in %0d color settings,",
			rows_sent, rows_checked, NUM_PHASES);
		$display("plain and outlined, with sender gaps, receiver stalls and a long output hold.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
